### src/vpows_pkg.sv
// ----------------------------------------------------------------------------
// vpows_pkg: shared types and constants for the one-wire voice prompt sender
// Holds the item opcodes, configuration register indexes and the fixed
// numbers of the prompt permission rules and of the line frame.
// ----------------------------------------------------------------------------
`default_nettype none

package vpows_pkg;

  // Kind of an input item.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PLAY   = 2'd1,
    OP_VOLUME = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PROMPT_MODE = 2'd0,
    REG_LANGUAGE    = 2'd1,
    REG_PLAY_VOLUME = 2'd2,
    REG_NONE        = 2'd3
  } cfg_reg_t;

  // Prompt modes.
  localparam logic [1:0] MODE_NONE       = 2'd0;
  localparam logic [1:0] MODE_POWERUP    = 2'd1;
  localparam logic [1:0] MODE_NO_POWERUP = 2'd2;
  localparam logic [1:0] MODE_ALL        = 2'd3;

  // Languages that select the odd byte.
  localparam logic [1:0] LANG_ODD_A = 2'd0;
  localparam logic [1:0] LANG_ODD_B = 2'd2;

  // Register reset values.
  localparam logic [1:0] PROMPT_MODE_RST = 2'd3;
  localparam logic [1:0] LANGUAGE_RST    = 2'd1;
  localparam logic [3:0] PLAY_VOLUME_RST = 4'd4;

  // Prompt ranges.
  localparam logic [7:0] ALWAYS_LO    = 8'd42;
  localparam logic [7:0] ALWAYS_HI    = 8'd53;
  localparam logic [7:0] POWERUP_LO   = 8'd61;
  localparam logic [7:0] POWERUP_HI   = 8'd70;
  localparam logic [7:0] POWERUP_ONE  = 8'd89;
  localparam logic [7:0] POWERUP_LOW  = 8'd1;
  localparam logic [7:0] REPEAT_LO    = 8'd5;
  localparam logic [7:0] REPEAT_HI    = 8'd14;

  // Frame layout: eleven slots of four ticks, counted down.
  localparam logic [3:0] FRAME_SLOTS   = 4'd11;
  localparam logic [3:0] LAST_DATA_IDX = 4'd9;
  localparam logic [3:0] STOP_SLOT     = 4'd1;
  localparam logic [1:0] SUB_FIRST     = 2'd3;
  localparam logic [1:0] SUB_VALUE     = 2'd2;
  localparam logic [7:0] VOL_BASE      = 8'hA8;

endpackage

`default_nettype wire

### src/voice_prompt_one_wire_sender.sv
// ----------------------------------------------------------------------------
// voice_prompt_one_wire_sender: frames prompt and volume bytes onto one wire
// Takes tick, play and volume items and reports the line level per item.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in_ stream: in_tuser carries the opcode (tick,
// play request or volume request) and in_tdata the prompt number and the
// volume level. Every accepted item gives exactly one result on the out_
// stream: the level of the one-wire line after the item, a busy flag that
// stays high while frame ticks remain, and a flag that says whether the item
// loaded a new frame. The cfg_ port writes prompt mode, language and play
// volume; it is meant to be used while no item is in flight.
// An accepted item is held in the input register, is processed against the
// frame state as it moves into the output register, and its result is
// offered from there. Throughput is one item per cycle while the receiver
// does not stall, set by the single frame-state update done in the
// processing stage. If the receiver stalls, the result is held in the output
// register and the input register still takes one more item; after that
// in_tready falls until the result is taken. Reset clears both stages, sets
// the line high, the frame idle and the registers to prompt mode 3,
// language 1, volume 4.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_prompt_one_wire_sender (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input item stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] prompt_number, [11:8] volume_level, rest 0
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] line_level, [1] busy_res, [2] accepted, rest 0
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [3:0]  cfg_wdata
);

  // Configuration registers.
  logic [1:0] prompt_mode_r;
  logic [1:0] language_r;
  logic [3:0] play_volume_r;

  // Input register.
  logic       s1_valid_r;
  logic [1:0] s1_op_r;
  logic [7:0] s1_prompt_r;
  logic [3:0] s1_level_r;

  // Frame state.
  logic [3:0] bit_slot_r, bit_slot_nxt;
  logic [1:0] sub_tick_r, sub_tick_nxt;
  logic [7:0] frame_byte_r, frame_byte_nxt;
  logic [7:0] last_prompt_r, last_prompt_nxt;
  logic       line_r, line_nxt;

  // Output register.
  logic       out_valid_r;
  logic [2:0] out_res_r;
  logic       acc_nxt;

  logic       s1_advance;
  logic       powerup;
  logic       always_ok;
  logic       permit;
  logic       repeat_range;
  logic [7:0] play_byte;
  logic [3:0] bit_idx_w;
  logic       data_bit;

  // The processing stage moves when the output register is free or emptying.
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prompt_mode_r <= vpows_pkg::PROMPT_MODE_RST;
      language_r    <= vpows_pkg::LANGUAGE_RST;
      play_volume_r <= vpows_pkg::PLAY_VOLUME_RST;
    end else if (cfg_we) begin
      unique case (vpows_pkg::cfg_reg_t'(cfg_addr))
        vpows_pkg::REG_PROMPT_MODE: prompt_mode_r <= cfg_wdata[1:0];
        vpows_pkg::REG_LANGUAGE:    language_r    <= cfg_wdata[1:0];
        vpows_pkg::REG_PLAY_VOLUME: play_volume_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r     <= in_tuser;
      s1_prompt_r <= in_tdata[7:0];
      s1_level_r  <= in_tdata[11:8];
    end
  end

  // Prompt permission.
  assign powerup = (s1_prompt_r <= vpows_pkg::POWERUP_LOW)
                || ((s1_prompt_r >= vpows_pkg::POWERUP_LO)
                    && (s1_prompt_r <= vpows_pkg::POWERUP_HI))
                || (s1_prompt_r == vpows_pkg::POWERUP_ONE);
  assign always_ok = (s1_prompt_r >= vpows_pkg::ALWAYS_LO)
                  && (s1_prompt_r <= vpows_pkg::ALWAYS_HI);

  always_comb begin
    permit = 1'b0;
    unique case (prompt_mode_r)
      vpows_pkg::MODE_NONE:       permit = 1'b0;
      vpows_pkg::MODE_POWERUP:    permit = always_ok || powerup;
      vpows_pkg::MODE_NO_POWERUP: permit = always_ok || !powerup;
      vpows_pkg::MODE_ALL:        permit = 1'b1;
      default:                    permit = 1'b0;
    endcase
  end

  assign repeat_range = (s1_prompt_r >= vpows_pkg::REPEAT_LO)
                     && (s1_prompt_r <= vpows_pkg::REPEAT_HI);

  // Twice the prompt, wrapping at 256, plus one for the odd-byte languages.
  assign play_byte = {s1_prompt_r[6:0],
                      (language_r == vpows_pkg::LANG_ODD_A)
                      || (language_r == vpows_pkg::LANG_ODD_B)};

  // Data slots 9 down to 2 carry bits 0 up to 7.
  assign bit_idx_w = vpows_pkg::LAST_DATA_IDX - bit_slot_r;
  assign data_bit  = frame_byte_r[bit_idx_w[2:0]];

  // Frame state update for the item in the input register.
  always_comb begin
    bit_slot_nxt    = bit_slot_r;
    sub_tick_nxt    = sub_tick_r;
    frame_byte_nxt  = frame_byte_r;
    last_prompt_nxt = last_prompt_r;
    line_nxt        = line_r;
    acc_nxt         = 1'b0;
    unique case (vpows_pkg::opcode_t'(s1_op_r))
      vpows_pkg::OP_TICK: begin
        if (bit_slot_r != 4'd0) begin
          if (bit_slot_r > vpows_pkg::LAST_DATA_IDX) begin
            line_nxt = 1'b0;
          end else if (bit_slot_r == vpows_pkg::STOP_SLOT) begin
            line_nxt = 1'b1;
          end else if (sub_tick_r == vpows_pkg::SUB_FIRST) begin
            line_nxt = 1'b1;
          end else if (sub_tick_r == vpows_pkg::SUB_VALUE) begin
            line_nxt = data_bit;
          end else begin
            line_nxt = 1'b0;
          end
          if (sub_tick_r == 2'd0) begin
            bit_slot_nxt = bit_slot_r - 4'd1;
            sub_tick_nxt = vpows_pkg::SUB_FIRST;
          end else begin
            sub_tick_nxt = sub_tick_r - 2'd1;
          end
        end
      end
      vpows_pkg::OP_PLAY: begin
        if (permit && !(repeat_range && (last_prompt_r == s1_prompt_r))) begin
          last_prompt_nxt = repeat_range ? s1_prompt_r : 8'd0;
          if (play_volume_r != 4'd0) begin
            frame_byte_nxt = play_byte;
            bit_slot_nxt   = vpows_pkg::FRAME_SLOTS;
            sub_tick_nxt   = vpows_pkg::SUB_FIRST;
            acc_nxt        = 1'b1;
          end
        end
      end
      vpows_pkg::OP_VOLUME: begin
        last_prompt_nxt = 8'd0;
        frame_byte_nxt  = vpows_pkg::VOL_BASE + {4'd0, s1_level_r};
        bit_slot_nxt    = vpows_pkg::FRAME_SLOTS;
        sub_tick_nxt    = vpows_pkg::SUB_FIRST;
        acc_nxt         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_slot_r    <= 4'd0;
      sub_tick_r    <= 2'd0;
      frame_byte_r  <= 8'd0;
      last_prompt_r <= 8'd0;
      line_r        <= 1'b1;
    end else if (s1_advance) begin
      bit_slot_r    <= bit_slot_nxt;
      sub_tick_r    <= sub_tick_nxt;
      frame_byte_r  <= frame_byte_nxt;
      last_prompt_r <= last_prompt_nxt;
      line_r        <= line_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res_r <= {acc_nxt, bit_slot_nxt != 4'd0, line_nxt};
    end
  end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the one-wire voice prompt sender
// Sends tick, play, volume and unused-opcode items with random gaps while the result side
// stalls at random, keeps its own model of the frame shifter and the prompt
// rules, and checks line level, busy and accept flags of every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound for roughly 1300 items plus the idle pauses around every
  // change of settings.
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] prompt_number, [11:8] volume_level, rest 0
  logic [1:0]  in_tuser;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] line_level, [1] busy_res, [2] accepted, rest 0
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [3:0]  cfg_wdata;

  voice_prompt_one_wire_sender dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // What the block should report after one item.
  typedef struct packed {
    logic accepted;
    logic busy;
    logic line;
  } line_report_t;

  // Reports still owed by the block, oldest first.
  line_report_t expected_reports[$];

  // Our own copy of the frame shifter and the prompt bookkeeping.
  logic [3:0] slot_left;
  logic [1:0] sub_phase;
  logic [7:0] frame_bits;
  logic [7:0] recent_prompt;
  logic       line_now;

  // Our own copy of the configuration registers.
  logic [1:0] mode_cfg;
  logic [1:0] lang_cfg;
  logic [3:0] vol_cfg;

  int          mismatches = 0;
  int unsigned cycle_count = 0;

  // When set, the sending or the receiving side runs without any idling.
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // The permission rule. Prompts in the always band pass in every mode except
  // the silent one; the power-up set is what separates modes one and two.
  function automatic logic prompt_permitted(logic [7:0] p);
    logic powerup;
    powerup = (p <= vpows_pkg::POWERUP_LOW) ||
              (p >= vpows_pkg::POWERUP_LO && p <= vpows_pkg::POWERUP_HI) ||
              (p == vpows_pkg::POWERUP_ONE);
    if (mode_cfg != vpows_pkg::MODE_NONE && p >= vpows_pkg::ALWAYS_LO &&
        p <= vpows_pkg::ALWAYS_HI) return 1'b1;
    case (mode_cfg)
      vpows_pkg::MODE_POWERUP:    return powerup;
      vpows_pkg::MODE_NO_POWERUP: return !powerup;
      vpows_pkg::MODE_ALL:        return 1'b1;
      default:                    return 1'b0;
    endcase
  endfunction

  // Loading a frame leaves the line where it is; only ticks move it.
  function automatic void start_frame(logic [7:0] value);
    frame_bits = value;
    slot_left  = vpows_pkg::FRAME_SLOTS;
    sub_phase  = vpows_pkg::SUB_FIRST;
  endfunction

  // One tick of the frame: two low slots, eight data slots sent LSB first as
  // high, bit, low, low, and a closing high slot. Slots count down from
  // eleven and each slot lasts four ticks.
  function automatic void shift_one_tick();
    logic       data_bit;
    logic [3:0] bit_idx;
    if (slot_left == 4'd0) return;
    if (slot_left > vpows_pkg::LAST_DATA_IDX) begin
      line_now = 1'b0;
    end else if (slot_left == vpows_pkg::STOP_SLOT) begin
      line_now = 1'b1;
    end else begin
      bit_idx  = vpows_pkg::LAST_DATA_IDX - slot_left;
      data_bit = frame_bits[bit_idx[2:0]];
      if (sub_phase == vpows_pkg::SUB_FIRST) line_now = 1'b1;
      else if (sub_phase == vpows_pkg::SUB_VALUE) line_now = data_bit;
      else line_now = 1'b0;
    end
    if (sub_phase == 2'd0) begin
      slot_left = slot_left - 4'd1;
      sub_phase = vpows_pkg::SUB_FIRST;
    end else begin
      sub_phase = sub_phase - 2'd1;
    end
  endfunction

  // A play request. The repeat guard is updated even when the volume mutes
  // the request, so a muted prompt still blocks its own immediate repeat.
  function automatic logic request_prompt(logic [7:0] p);
    logic [7:0] value;
    if (!prompt_permitted(p)) return 1'b0;
    if (p >= vpows_pkg::REPEAT_LO && p <= vpows_pkg::REPEAT_HI) begin
      if (recent_prompt == p) return 1'b0;
      recent_prompt = p;
    end else begin
      recent_prompt = 8'd0;
    end
    if (vol_cfg == 4'd0) return 1'b0;
    value = {p[6:0], 1'b0};
    if (lang_cfg == vpows_pkg::LANG_ODD_A || lang_cfg == vpows_pkg::LANG_ODD_B)
      value = value + 8'd1;
    start_frame(value);
    return 1'b1;
  endfunction

  function automatic line_report_t predict_report(vpows_pkg::opcode_t op,
                                                  logic [7:0] p,
                                                  logic [3:0] lvl);
    line_report_t rep;
    rep.accepted = 1'b0;
    case (op)
      vpows_pkg::OP_TICK:   shift_one_tick();
      vpows_pkg::OP_PLAY:   rep.accepted = request_prompt(p);
      vpows_pkg::OP_VOLUME: begin
        recent_prompt = 8'd0;
        start_frame(vpows_pkg::VOL_BASE + {4'd0, lvl});
        rep.accepted = 1'b1;
      end
      default: ;
    endcase
    rep.line = line_now;
    rep.busy = (slot_left != 4'd0);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Driving the block
  // --------------------------------------------------------------------------

  // Offers one item after a random gap and waits for the block to take it.
  // The valid line is left high afterwards so that back-to-back items need
  // no second assignment in the same time step; whoever comes next lowers it.
  task automatic send_item(vpows_pkg::opcode_t op, logic [7:0] p = 8'd0,
                           logic [3:0] lvl = 4'd0);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, lvl, p};
    do @(posedge clk); while (!in_tready);
    expected_reports.push_back(predict_report(op, p, lvl));
  endtask

  // Stops sending, waits until every owed report has come back and then
  // idles so that the two-stage pipeline is certainly empty.
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers, one per cycle, while the block is idle.
  task automatic apply_settings(logic [1:0] mode, logic [1:0] lang, logic [3:0] vol);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= vpows_pkg::REG_PROMPT_MODE;
    cfg_wdata <= {2'b00, mode};
    @(posedge clk);
    cfg_addr  <= vpows_pkg::REG_LANGUAGE;
    cfg_wdata <= {2'b00, lang};
    @(posedge clk);
    cfg_addr  <= vpows_pkg::REG_PLAY_VOLUME;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_cfg = mode;
    lang_cfg = lang;
    vol_cfg  = vol;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, and each report checked against the oldest
  // prediction.
  // --------------------------------------------------------------------------

  function automatic void compare_flag(string what, logic want, logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0b actual %0b", $time, what, want, got);
    end
  endfunction

  initial begin : report_checker
    line_report_t want;
    int stall;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      // Every fifty reports decide afresh whether to stall at all.
      if (taken % 50 == 0) take_burst = ($urandom_range(0, 3) == 0);
      stall = take_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t ns: report expected none actual %0h", $time, out_tdata);
      end else begin
        want = expected_reports.pop_front();
        compare_flag("line_level", want.line, out_tdata[0]);
        compare_flag("busy_res", want.busy, out_tdata[1]);
        compare_flag("accepted", want.accepted, out_tdata[2]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight out of reset the line is high and nothing is pending. A tick
  // with no frame, and the unused opcode, must leave everything as it is.
  task automatic test_idle_line();
    send_item(vpows_pkg::OP_TICK);
    send_item(vpows_pkg::OP_UNUSED, 8'hFF, 4'hF);
  endtask

  // A volume frame with the top level, a few ticks into it, then a second
  // volume request with the lowest level that restarts the frame.
  task automatic test_frame_restart();
    send_item(vpows_pkg::OP_VOLUME, 8'd0, 4'd15);
    repeat (3) send_item(vpows_pkg::OP_TICK);
    send_item(vpows_pkg::OP_VOLUME, 8'hFF, 4'd0);
    send_item(vpows_pkg::OP_TICK);
  endtask

  // The silent mode refuses even the always band; mode one passes only the
  // power-up set and the always band; mode two passes all but power-up.
  task automatic test_permission_modes();
    apply_settings(vpows_pkg::MODE_NONE, 2'd1, 4'd4);
    send_item(vpows_pkg::OP_PLAY, vpows_pkg::ALWAYS_LO);
    apply_settings(vpows_pkg::MODE_POWERUP, 2'd1, 4'd4);
    send_item(vpows_pkg::OP_PLAY, 8'd0);
    send_item(vpows_pkg::OP_PLAY, vpows_pkg::POWERUP_ONE);
    send_item(vpows_pkg::OP_PLAY, vpows_pkg::ALWAYS_HI);
    send_item(vpows_pkg::OP_PLAY, 8'd100);
    apply_settings(vpows_pkg::MODE_NO_POWERUP, 2'd1, 4'd4);
    send_item(vpows_pkg::OP_PLAY, vpows_pkg::POWERUP_LO);
    send_item(vpows_pkg::OP_PLAY, 8'd255);
  endtask

  // A repeatable prompt twice in a row is dropped the second time; a volume
  // request in between clears the memory. With the volume at zero the play
  // request is muted but still remembered, so its repeat is dropped later.
  task automatic test_repeat_guard_and_mute();
    apply_settings(vpows_pkg::MODE_ALL, 2'd1, 4'd15);
    send_item(vpows_pkg::OP_PLAY, 8'd7);
    send_item(vpows_pkg::OP_PLAY, 8'd7);
    send_item(vpows_pkg::OP_VOLUME, 8'd0, 4'd3);
    send_item(vpows_pkg::OP_PLAY, 8'd7);
    apply_settings(vpows_pkg::MODE_ALL, 2'd1, 4'd0);
    send_item(vpows_pkg::OP_PLAY, 8'd9);
    apply_settings(vpows_pkg::MODE_ALL, 2'd1, 4'd1);
    send_item(vpows_pkg::OP_PLAY, 8'd9);
    send_item(vpows_pkg::OP_PLAY, vpows_pkg::REPEAT_HI);
  endtask

  // Byte forming: the doubled prompt wraps at 256, the two odd languages add
  // one, and language three behaves like the even language.
  task automatic test_byte_forming();
    apply_settings(vpows_pkg::MODE_ALL, vpows_pkg::LANG_ODD_A, 4'd15);
    send_item(vpows_pkg::OP_PLAY, 8'd255);
    apply_settings(vpows_pkg::MODE_ALL, vpows_pkg::LANG_ODD_B, 4'd15);
    send_item(vpows_pkg::OP_PLAY, 8'd128);
    apply_settings(vpows_pkg::MODE_ALL, 2'd3, 4'd15);
    send_item(vpows_pkg::OP_PLAY, 8'd200);
  endtask

  // Random traffic in six phases of settings. Most of it is a request
  // followed by the ticks that shift its frame out, now and then cut short
  // so the next request restarts the frame; the rest is stray ticks and the
  // unused opcode.
  task automatic test_random_traffic();
    int         phase;
    int         sent;
    int         run;
    logic [7:0] p;
    logic [3:0] lvl;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       apply_settings(vpows_pkg::MODE_ALL, 2'd1, 4'd4);
        1:       apply_settings(vpows_pkg::MODE_NONE, 2'd0, 4'd0);
        2:       apply_settings(vpows_pkg::MODE_POWERUP, 2'd2, 4'd15);
        3:       apply_settings(vpows_pkg::MODE_NO_POWERUP, 2'd0, 4'd1);
        4:       apply_settings(vpows_pkg::MODE_ALL, 2'd3, 4'd15);
        default: apply_settings(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                4'($urandom_range(0, 15)));
      endcase
      sent = 0;
      while (sent < 215) begin
        send_burst = ($urandom_range(0, 3) == 0);
        p   = 8'($urandom_range(0, 255));
        lvl = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0: begin
            send_item(vpows_pkg::OP_UNUSED, p, lvl);
            sent++;
          end
          1: begin
            run = $urandom_range(1, 6);
            repeat (run) send_item(vpows_pkg::OP_TICK, p, lvl);
            sent += run;
          end
          default: begin
            if ($urandom_range(0, 4) < 3) begin
              // Bias the prompt towards the bands that the rules single out.
              case ($urandom_range(0, 9))
                0, 1, 2: p = 8'($urandom_range(vpows_pkg::REPEAT_LO, vpows_pkg::REPEAT_HI));
                3:       p = 8'($urandom_range(vpows_pkg::POWERUP_LO, vpows_pkg::POWERUP_HI));
                4:       p = $urandom_range(0, 1) ? vpows_pkg::POWERUP_ONE
                                                  : 8'($urandom_range(0, 1));
                5:       p = 8'($urandom_range(vpows_pkg::ALWAYS_LO, vpows_pkg::ALWAYS_HI));
                default: ;
              endcase
              send_item(vpows_pkg::OP_PLAY, p, lvl);
            end else begin
              send_item(vpows_pkg::OP_VOLUME, p, lvl);
            end
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 43)
                                              : $urandom_range(44, 48);
            repeat (run) send_item(vpows_pkg::OP_TICK, p, lvl);
            sent += run + 1;
          end
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 16'd0;
    in_tuser  <= vpows_pkg::OP_TICK;
    cfg_we    <= 1'b0;
    cfg_addr  <= vpows_pkg::REG_PROMPT_MODE;
    cfg_wdata <= 4'd0;

    // Model state and registers as the block holds them after reset.
    slot_left     = 4'd0;
    sub_phase     = 2'd0;
    frame_bits    = 8'd0;
    recent_prompt = 8'd0;
    line_now      = 1'b1;
    mode_cfg      = vpows_pkg::PROMPT_MODE_RST;
    lang_cfg      = vpows_pkg::LANGUAGE_RST;
    vol_cfg       = vpows_pkg::PLAY_VOLUME_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_line();
    test_frame_restart();
    test_permission_modes();
    test_repeat_guard_and_mute();
    test_byte_forming();
    test_random_traffic();

    // Drain: every report back, then a little longer to catch strays.
    settle_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
